/* hw/rtl/dmc_pkg.sv */
// Shared types and constants of the direct-mapped cache tag check unit.
`timescale 1ns / 1ps

package dmc_pkg;

    // Field widths
    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 32;
    localparam int TAG_W       = 30;
    localparam int IDX_MAX_W   = 7;   // lines_log2 is at most 7
    localparam int LG_W        = 3;
    localparam int BW_W        = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 3;
    localparam int WORD_BYTES_LOG2 = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_LOG2       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS_LOG2 = 1'b1;

    // Configuration reset values
    localparam logic [LG_W-1:0] LINES_LOG2_RST       = 3'd6;
    localparam logic [BW_W-1:0] BLOCK_WORDS_LOG2_RST = 2'd0;

    // Input actions
    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    // Classified operation passed from front to back
    typedef struct packed {
        logic                 clear;
        logic [IDX_MAX_W-1:0] idx;
        logic [TAG_W-1:0]     tag;
    } dmc_op_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } dmc_q_stat_t;

endpackage

/* hw/rtl/dmc_if.sv */
// Channel interfaces: configuration writes, access requests and results.
`timescale 1ns / 1ps

interface dmc_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [2:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface dmc_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] address;

    modport source (output valid, output action, output address, input ready);
    modport sink   (input valid, input action, input address, output ready);
endinterface

interface dmc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] request_count;
    logic [31:0] hit_count;
    logic [31:0] fetch_count;

    modport source (output valid, output hit, output request_count, output hit_count,
                    output fetch_count, input ready);
    modport sink   (input valid, input hit, input request_count, input hit_count,
                    input fetch_count, output ready);
endinterface

/* hw/rtl/dmc_front.sv */
// Front end: configuration registers, request intake and index/tag split.
`timescale 1ns / 1ps

module dmc_front #(
    parameter int LINES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    dmc_cfg_if.sink             cfg,
    dmc_req_if.sink             req,
    input  dmc_pkg::dmc_q_stat_t q_stat,
    output logic                push,
    output dmc_pkg::dmc_op_t    push_op
);
    import dmc_pkg::*;

    // Largest usable log2 of the line count
    localparam int LG_FLOOR = $clog2(LINES + 1) - 1;
    localparam int LG_TOP   = (LG_FLOOR > 7) ? 7 : LG_FLOOR;
    localparam logic [LG_W-1:0] LG_TOP_V = LG_W'(LG_TOP);

    logic [LG_W-1:0]      lines_log2_reg;
    logic [BW_W-1:0]      block_words_log2_reg;
    logic [LG_W-1:0]      lg;
    logic [2:0]           shamt;
    logic [ADDR_W-1:0]    shifted;
    logic [TAG_W-1:0]     block;
    logic [IDX_MAX_W-1:0] idx_mask;

    // Configuration writes, always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_log2_reg       <= LINES_LOG2_RST;
            block_words_log2_reg <= BLOCK_WORDS_LOG2_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_LINES_LOG2:       lines_log2_reg       <= cfg.data;
                CFG_BLOCK_WORDS_LOG2: block_words_log2_reg <= cfg.data[BW_W-1:0];
                default:              ;
            endcase
        end
    end

    // Clamp line count to what the tag store holds
    assign lg = (lines_log2_reg > LG_TOP_V) ? LG_TOP_V : lines_log2_reg;

    // Block address, then index and tag
    assign shamt    = 3'(WORD_BYTES_LOG2) + {1'b0, block_words_log2_reg};
    assign shifted  = req.address >> shamt;
    assign block    = shifted[TAG_W-1:0];
    assign idx_mask = IDX_MAX_W'((8'd1 << lg) - 8'd1);

    always_comb
    begin
        push_op.clear = (req.action == ACT_CLEAR);
        push_op.idx   = block[IDX_MAX_W-1:0] & idx_mask;
        push_op.tag   = block >> lg;
    end

    // Transfer into the queue when it has room
    assign req.ready = !q_stat.full;
    assign push      = req.valid && !q_stat.full;

endmodule

/* hw/rtl/dmc_queue.sv */
// Two-entry queue of classified operations between front and back.
`timescale 1ns / 1ps

module dmc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dmc_pkg::dmc_op_t     push_op,
    input  logic                 pop,
    output dmc_pkg::dmc_op_t     pop_op,
    output dmc_pkg::dmc_q_stat_t q_stat
);
    import dmc_pkg::*;

    dmc_op_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // Pointers and fill count
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign pop_op           = entry_reg[rd_ptr_reg];
    assign q_stat.full      = (count_reg == 2'd2);
    assign q_stat.not_empty = (count_reg != 2'd0);

endmodule

/* hw/rtl/dmc_back.sv */
// Back end: tag store lookup and update, statistics counters, result register.
`timescale 1ns / 1ps

module dmc_back #(
    parameter int LINES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dmc_pkg::dmc_q_stat_t q_stat,
    input  dmc_pkg::dmc_op_t     pop_op,
    output logic                 pop,
    dmc_rsp_if.source            rsp
);
    import dmc_pkg::*;

    localparam int LG_FLOOR = $clog2(LINES + 1) - 1;
    localparam int LG_TOP   = (LG_FLOOR > 7) ? 7 : LG_FLOOR;
    localparam int DEPTH    = 1 << LG_TOP;
    localparam int IDX_W    = (LG_TOP == 0) ? 1 : LG_TOP;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic             state_reg;
    logic             state_next;
    dmc_op_t          op_reg;
    logic [TAG_W-1:0] tag_mem [DEPTH];
    logic [TAG_W-1:0] rd_tag_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [CNT_W-1:0] req_cnt_reg;
    logic [CNT_W-1:0] req_cnt_next;
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] fetch_cnt_reg;
    logic [CNT_W-1:0] fetch_cnt_next;
    logic             rsp_valid_reg;
    logic             rsp_hit_reg;
    logic [CNT_W-1:0] rsp_req_reg;
    logic [CNT_W-1:0] rsp_hits_reg;
    logic [CNT_W-1:0] rsp_fetch_reg;
    logic [IDX_W-1:0] pop_idx;
    logic [IDX_W-1:0] look_idx;
    logic             done;
    logic             is_hit;
    logic             wr_en;

    assign pop_idx  = pop_op.idx[IDX_W-1:0];
    assign look_idx = op_reg.idx[IDX_W-1:0];

    // Sequencer: read the tag, then resolve once the result register is free
    assign pop  = (state_reg == S_IDLE) && q_stat.not_empty;
    assign done = (state_reg == S_LOOK) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (pop)  state_next = S_LOOK;
            S_LOOK: if (done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Hit check and counter updates
    assign is_hit = !op_reg.clear && valid_reg[look_idx] && (rd_tag_reg == op_reg.tag);
    assign wr_en  = done && !op_reg.clear && !is_hit;

    always_comb
    begin
        if (op_reg.clear)
        begin
            req_cnt_next   = '0;
            hit_cnt_next   = '0;
            fetch_cnt_next = '0;
        end
        else
        begin
            req_cnt_next   = req_cnt_reg + 32'd1;
            hit_cnt_next   = is_hit ? hit_cnt_reg + 32'd1 : hit_cnt_reg;
            fetch_cnt_next = is_hit ? fetch_cnt_reg : fetch_cnt_reg + 32'd1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            req_cnt_reg   <= '0;
            hit_cnt_reg   <= '0;
            fetch_cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                req_cnt_reg   <= req_cnt_next;
                hit_cnt_reg   <= hit_cnt_next;
                fetch_cnt_reg <= fetch_cnt_next;
                if (op_reg.clear)
                begin
                    valid_reg <= '0;
                end
                else if (wr_en)
                begin
                    valid_reg[look_idx] <= 1'b1;
                end
            end
            if (done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Operation latch, result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg <= pop_op;
        end
        if (done)
        begin
            rsp_hit_reg   <= is_hit;
            rsp_req_reg   <= req_cnt_next;
            rsp_hits_reg  <= hit_cnt_next;
            rsp_fetch_reg <= fetch_cnt_next;
        end
    end

    // Tag store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[look_idx] <= op_reg.tag;
        end
        if (pop)
        begin
            rd_tag_reg <= tag_mem[pop_idx];
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.hit           = rsp_hit_reg;
    assign rsp.request_count = rsp_req_reg;
    assign rsp.hit_count     = rsp_hits_reg;
    assign rsp.fetch_count   = rsp_fetch_reg;

endmodule

/* hw/rtl/direct_mapped_cache_tag_check_unit.sv */
// Top level of the direct-mapped cache tag check unit.
//
//  Channel | Dir | Payload                                          | Transfer
//  cfg     | in  | index, data (lines_log2, block_words_log2)       | valid & ready
//  req     | in  | action, address                                  | valid & ready
//  rsp     | out | hit, request_count, hit_count, fetch_count       | valid & ready
//
// Each item passes two back-end states: a tag store read, then the compare/update
// state that loads the result register once it is free, and no new item is taken
// before then. Requests pass the queue, tag read and result registers to rsp.
// Reset clears the line valid flops and counters at once; no clearing pass.
// A two-entry queue lets requests transfer while a result waits on rsp.ready.
`timescale 1ns / 1ps

module direct_mapped_cache_tag_check_unit #(
    parameter int LINES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    dmc_cfg_if.sink   cfg,
    dmc_req_if.sink   req,
    dmc_rsp_if.source rsp
);
    import dmc_pkg::*;

    dmc_q_stat_t q_stat;
    dmc_op_t     push_op;
    dmc_op_t     pop_op;
    logic        push;
    logic        pop;

    // Intake and classification
    dmc_front #(
        .LINES (LINES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .req     (req),
        .q_stat  (q_stat),
        .push    (push),
        .push_op (push_op)
    );

    // Decoupling queue
    dmc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .q_stat  (q_stat)
    );

    // Lookup, update and results
    dmc_back #(
        .LINES (LINES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .pop_op (pop_op),
        .pop    (pop),
        .rsp    (rsp)
    );

endmodule

/* hw/rtl/dmc_checker.sv */
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps

module dmc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_hit,
    input logic [31:0] rsp_request_count,
    input logic [31:0] rsp_hit_count,
    input logic [31:0] rsp_fetch_count
);

    // A waiting result stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before transfer");

    // A waiting result keeps its request and hit counts
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_request_count) && $stable(rsp_hit_count))
        else $error("result payload changed while stalled");

    // Every access is either a hit or a fetch
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_request_count == 32'(rsp_hit_count + rsp_fetch_count))
        else $error("request count differs from hits plus fetches");

    // A hit result has counted itself
    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_hit |-> rsp_hit_count != 32'd0)
        else $error("hit reported with zero hit count");

endmodule

bind direct_mapped_cache_tag_check_unit dmc_checker u_dmc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_hit           (rsp.hit),
    .rsp_request_count (rsp.request_count),
    .rsp_hit_count     (rsp.hit_count),
    .rsp_fetch_count   (rsp.fetch_count)
);

/* sim/dmc_check.sv */
// Scoreboard for the cache tag check unit: tracks config, predicts every result and compares.
`timescale 1ns / 1ps

module dmc_check #(
    parameter int LINES = 64
) (
    input  logic clk,
    input  logic rst_n,
    dmc_cfg_if   cfg,
    dmc_req_if   req,
    dmc_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);
    import dmc_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] requests;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] fetches;
    } lookup_result_t;

    lookup_result_t   expected_results [$];

    // Shadow tag store, counters and config
    logic             line_ok  [LINES];
    logic [TAG_W-1:0] line_tag [LINES];
    logic [CNT_W-1:0] n_requests;
    logic [CNT_W-1:0] n_hits;
    logic [CNT_W-1:0] n_fetches;
    logic [LG_W-1:0]  lines_lg;
    logic [BW_W-1:0]  words_lg;

    // Invalidate every line and zero the counters
    function automatic void flush_cache();
        for (int i = 0; i < LINES; i++)
        begin
            line_ok[i]  = 1'b0;
            line_tag[i] = '0;
        end
        n_requests = '0;
        n_hits     = '0;
        n_fetches  = '0;
    endfunction

    // Apply one request to the shadow store and return the result it should produce
    function automatic lookup_result_t cache_lookup(input logic act,
                                                    input logic [ADDR_W-1:0] addr);
        lookup_result_t   res;
        int unsigned      lg;
        logic [ADDR_W-1:0] blk;
        int unsigned      idx;
        logic [TAG_W-1:0] tg;

        res.hit = 1'b0;
        if (act == ACT_CLEAR)
        begin
            flush_cache();
        end
        else
        begin
            // line count saturates at the physical line count
            lg = lines_lg;
            while (lg > 0 && (1 << lg) > LINES)
                lg--;
            blk = addr >> (WORD_BYTES_LOG2 + words_lg);
            idx = blk & ((32'd1 << lg) - 32'd1);
            tg  = TAG_W'(blk >> lg);
            n_requests++;
            if (line_ok[idx] && line_tag[idx] == tg)
            begin
                n_hits++;
                res.hit = 1'b1;
            end
            else
            begin
                line_ok[idx]  = 1'b1;
                line_tag[idx] = tg;
                n_fetches++;
            end
        end
        res.requests = n_requests;
        res.hits     = n_hits;
        res.fetches  = n_fetches;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result transfers are checked before new requests are queued
    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;

        if (!rst_n)
        begin
            lines_lg   = LINES_LOG2_RST;
            words_lg   = BLOCK_WORDS_LOG2_RST;
            flush_cache();
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("hit", CNT_W'(want.hit), CNT_W'(rsp.hit));
                    check_field("request_count", want.requests, rsp.request_count);
                    check_field("hit_count", want.hits, rsp.hit_count);
                    check_field("fetch_count", want.fetches, rsp.fetch_count);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_LINES_LOG2)
                    lines_lg = cfg.data[LG_W-1:0];
                else if (cfg.index == CFG_BLOCK_WORDS_LOG2)
                    words_lg = cfg.data[BW_W-1:0];
            end
            if (req.valid && req.ready)
                expected_results.push_back(cache_lookup(req.action, req.address));
        end
        pending = expected_results.size();
    end

endmodule

/* sim/tb.sv */
// Top of the cache tag check unit bench: clock, reset, stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb;
    import dmc_pkg::*;

    localparam int LINES        = 64;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 130;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   src_idle;
    int   snk_idle;
    int   calm;
    int   sent;

    logic [ADDR_W-1:0] recent [8];

    // Config plan per phase; includes both extremes and an oversized line count
    int lg_plan [PHASES] = '{7, 0, 0, 6, 3, 7, 5, 2};
    int bw_plan [PHASES] = '{3, 0, 3, 1, 2, 0, 3, 1};

    dmc_cfg_if cfg_ch ();
    dmc_req_if req_ch ();
    dmc_rsp_if rsp_ch ();

    direct_mapped_cache_tag_check_unit #(
        .LINES (LINES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dmc_check #(
        .LINES (LINES)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5ms;
        $display("tb NOT OK");
        $finish;
    end

    // Result back-pressure; always ready during calm stretches
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = (calm > 0) || ($urandom_range(99) >= snk_idle);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // One request transfer; valid stays high into the next call unless it idles
    task automatic send_request(input logic act, input logic [ADDR_W-1:0] addr);
        while (calm == 0 && $urandom_range(99) < src_idle)
        begin
            req_ch.valid   = 1'b0;
            req_ch.address = $urandom;
            @(negedge clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.action  = act;
        req_ch.address = addr;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        if (calm > 0)
            calm--;
        else if ($urandom_range(99) < 3)
            calm = $urandom_range(10, 30);
        sent++;
    endtask

    task automatic drain();
        req_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Mostly reuse and conflict traffic around a small address pool so hits occur
    task automatic send_random();
        int                r;
        int                k;
        logic [ADDR_W-1:0] a;

        r = $urandom_range(99);
        k = $urandom_range(7);
        if (r < 5)
        begin
            send_request(ACT_CLEAR, $urandom);
        end
        else
        begin
            if (r < 50)
            begin
                // same word: same block in every config
                a = recent[k] ^ ADDR_W'($urandom_range(3));
            end
            else if (r < 70)
            begin
                // same index, new tag
                a = recent[k] ^ ($urandom << 12);
                recent[k] = a;
            end
            else if (r < 95)
            begin
                a = $urandom;
                recent[k] = a;
            end
            else
            begin
                case ($urandom_range(3))
                    0: a = 32'h0000_0000;
                    1: a = 32'hFFFF_FFFF;
                    2: a = 32'h8000_0000;
                    default: a = 32'h7FFF_FFFF;
                endcase
            end
            send_request(ACT_ACCESS, a);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_LINES_LOG2;
        cfg_ch.data    = '0;
        req_ch.valid   = 1'b0;
        req_ch.action  = ACT_ACCESS;
        req_ch.address = '0;
        src_idle       = 25;
        snk_idle       = 77;
        calm           = 0;
        sent           = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: hits, same-block offsets, conflicts, address extremes, clears
        send_request(ACT_ACCESS, 32'h0000_0000);
        send_request(ACT_ACCESS, 32'h0000_0000);
        send_request(ACT_ACCESS, 32'h0000_0003);
        send_request(ACT_ACCESS, 32'hFFFF_FFFF);
        send_request(ACT_ACCESS, 32'hFFFF_FFFC);
        send_request(ACT_ACCESS, 32'h8000_0000);
        send_request(ACT_ACCESS, 32'h0000_0000);
        send_request(ACT_ACCESS, 32'h0000_0100);
        send_request(ACT_ACCESS, 32'h7FFF_FFFF);
        send_request(ACT_CLEAR, 32'hFFFF_FFFF);
        send_request(ACT_ACCESS, 32'h0000_0000);
        send_request(ACT_ACCESS, 32'hFFFF_FFFF);
        send_request(ACT_CLEAR, 32'h0000_0000);
        send_request(ACT_CLEAR, 32'h5555_AAAA);
        send_request(ACT_ACCESS, 32'hFFFF_FFFF);
        drain();

        for (int i = 0; i < 8; i++)
            recent[i] = $urandom;

        // Random phases; lines survive config changes unless a clear comes by
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(CFG_LINES_LOG2, lg_plan[p]);
            write_reg(CFG_BLOCK_WORDS_LOG2, bw_plan[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (sent < 350)
                begin
                    src_idle = 25;
                    snk_idle = 77;
                end
                else if (sent < 700)
                begin
                    src_idle = 77;
                    snk_idle = 25;
                end
                else
                begin
                    src_idle = 0;
                    snk_idle = 0;
                end
                send_random();
            end
            drain();
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/dmc_pkg.sv
hw/rtl/dmc_if.sv
hw/rtl/dmc_front.sv
hw/rtl/dmc_queue.sv
hw/rtl/dmc_back.sv
hw/rtl/direct_mapped_cache_tag_check_unit.sv
hw/rtl/dmc_checker.sv
sim/dmc_check.sv
sim/tb.sv
